FILE: rtl/hsmru_pkg.sv
// Shared types and constants of the heard-station most-recently-heard table.
package hsmru_pkg;

  // Default table depth.
  localparam int unsigned HeardSlotsDef = 16;

  // Field widths.
  localparam int unsigned CallW  = 48;
  localparam int unsigned SsidW  = 4;
  localparam int unsigned CtlW   = 8;
  localparam int unsigned PidW   = 8;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned FlagW  = 3;
  localparam int unsigned SlotOutW  = 4;
  localparam int unsigned CountOutW = 5;
  localparam int unsigned CodeW  = 6;

  // Configuration port.
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 6;
  localparam logic [CfgIdxW-1:0] CfgHeardEnable  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgPidArp       = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgPidNetrom    = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgPidIp        = 2'd3;

  localparam logic [CodeW-1:0] PidArpRst    = 6'd13;
  localparam logic [CodeW-1:0] PidNetromRst = 6'd15;
  localparam logic [CodeW-1:0] PidIpRst     = 6'd12;

  // Frame type decode.
  localparam logic [CtlW-1:0] CtlPfClearMask = 8'hef;
  localparam logic [CtlW-1:0] CtlUi          = 8'h03;

  // Seen flags.
  localparam logic [FlagW-1:0] FlagArp    = 3'b001;
  localparam logic [FlagW-1:0] FlagNetrom = 3'b010;
  localparam logic [FlagW-1:0] FlagIp     = 3'b100;
  localparam logic [FlagW-1:0] FlagNone   = 3'b000;

  // One table entry as held in the entry RAM.
  typedef struct packed {
    logic [CallW-1:0] call;
    logic [SsidW-1:0] ssid;
    logic [FlagW-1:0] flags;
    logic [TimeW-1:0] heard;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  // Sequencer states, one-hot.
  typedef enum logic [6:0] {
    StIdle    = 7'b0000001,
    StWalkRd  = 7'b0000010,
    StWalkCmp = 7'b0000100,
    StDecide  = 7'b0001000,
    StLink1   = 7'b0010000,
    StLink2   = 7'b0100000,
    StDone    = 7'b1000000
  } state_e;

endpackage

FILE: rtl/heard_station_mru_table_top.sv
// Top level of the heard-station most-recently-heard table (move-to-front list).
//
//   channel   direction   handshake              payload
//   -------   ---------   --------------------   ------------------------------------------
//   in        sink        in_valid_i/in_stall_o   station_call, ssid, ctl/pid, now_seconds
//   out       source      out_valid_o/out_stall_i slot, hit, evict, flags, count, tracked
//   cfg       sink        cfg_we_i               cfg_index_i, cfg_wdata_i
//
// A hit ends the walk at the matching entry, a miss walks to the list end or the depth
// bound, and a disabled item skips the walk. The walk spends one registered RAM read and
// one shared call/SSID comparator on each entry; the next item is taken in the cycle
// after the result is loaded.
// Reset empties the list and zeroes the count; the RAMs stay uncleared, as the list only
// links written slots. A full, stalled output register holds the sequencer in its last state.

module heard_station_mru_table_top #(
  parameter int unsigned HeardSlots = hsmru_pkg::HeardSlotsDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,

  input  logic                               cfg_we_i,
  input  logic [hsmru_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [hsmru_pkg::CfgDataW-1:0]     cfg_wdata_i,

  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [hsmru_pkg::CallW-1:0]        station_call_i,
  input  logic [hsmru_pkg::SsidW-1:0]        station_ssid_i,
  input  logic                               has_ctl_pid_i,
  input  logic [hsmru_pkg::CtlW-1:0]         control_byte_i,
  input  logic [hsmru_pkg::PidW-1:0]         pid_byte_i,
  input  logic [hsmru_pkg::TimeW-1:0]        now_seconds_i,

  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [hsmru_pkg::SlotOutW-1:0]     slot_used_o,
  output logic                               was_hit_o,
  output logic                               evicted_oldest_o,
  output logic [hsmru_pkg::FlagW-1:0]        station_flags_o,
  output logic [hsmru_pkg::CountOutW-1:0]    entries_in_use_o,
  output logic                               tracked_o
);

  import hsmru_pkg::*;

  // Slot index width, and link/count width that also holds "none" = HeardSlots.
  localparam int unsigned SW = $clog2(HeardSlots);
  localparam int unsigned LW = $clog2(HeardSlots + 1);
  localparam logic [LW-1:0] LinkNone = LW'(HeardSlots);

  // Configuration registers.
  logic             enable_q;
  logic [CodeW-1:0] code_arp_q, code_netrom_q, code_ip_q;

  // Sequencer and list state.
  state_e state_q, state_d;
  logic [LW-1:0] head_q, used_q;

  // Item registers.
  logic [CallW-1:0] call_q;
  logic [SsidW-1:0] ssid_q;
  logic [TimeW-1:0] now_q;
  logic [FlagW-1:0] pid_flag_q;

  // Walk registers.
  logic [LW-1:0] curr_q, prev_q, before_q, nxt_q, steps_q;
  logic [FlagW-1:0] old_flags_q;

  // Result registers.
  logic [SW-1:0]    slot_q;
  logic             hit_q, evict_q, tracked_q;
  logic [FlagW-1:0] flags_q;

  // Planned link writes and list updates.
  logic          l1_en_q, l2_en_q, inc_q;
  logic [SW-1:0] l1_addr_q, l2_addr_q;
  logic [LW-1:0] l1_data_q, l2_data_q, head_new_q;

  // Output register.
  logic                 out_valid_q;
  logic [SlotOutW-1:0]  out_slot_q;
  logic                 out_hit_q, out_evict_q, out_tracked_q;
  logic [FlagW-1:0]     out_flags_q;
  logic [CountOutW-1:0] out_count_q;

  // RAM ports.
  entry_t        ent_rdata, ent_wdata;
  logic          ent_we;
  logic [LW-1:0] link_rdata, link_wdata;
  logic          link_we;
  logic [SW-1:0] link_waddr;

  logic in_accept, out_free;
  logic curr_valid, walk_end, match;
  logic [CodeW-1:0] pid_code;
  logic [FlagW-1:0] pid_flag;
  logic is_i, is_ui;
  logic [31:0] slot_ext, used_ext;

  assign in_accept = in_valid_i && (state_q == StIdle);
  assign out_free  = !out_valid_q || !out_stall_i;

  // Decode the flag this frame may set; first equal code wins.
  assign is_i     = !control_byte_i[0];
  assign is_ui    = (control_byte_i & CtlPfClearMask) == CtlUi;
  assign pid_code = pid_byte_i[CodeW-1:0];
  always_comb begin
    pid_flag = FlagNone;
    if (has_ctl_pid_i && (is_i || is_ui)) begin
      if (pid_code == code_arp_q) begin
        pid_flag = FlagArp;
      end else if (pid_code == code_netrom_q) begin
        pid_flag = FlagNetrom;
      end else if (pid_code == code_ip_q) begin
        pid_flag = FlagIp;
      end
    end
  end

  // Shared compare unit and walk bounds.
  assign curr_valid = curr_q < LinkNone;
  assign walk_end   = !curr_valid || (steps_q >= LinkNone);
  assign match      = (ent_rdata.call == call_q) && (ent_rdata.ssid == ssid_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_accept) begin
          state_d = enable_q ? StWalkRd : StDone;
        end
      end
      StWalkRd:  state_d = walk_end ? StDecide : StWalkCmp;
      StWalkCmp: state_d = match ? StDecide : StWalkRd;
      StDecide:  state_d = StLink1;
      StLink1:   state_d = StLink2;
      StLink2:   state_d = StDone;
      StDone:    state_d = out_free ? StIdle : StDone;
      default:   state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q      <= 1'b0;
      code_arp_q    <= PidArpRst;
      code_netrom_q <= PidNetromRst;
      code_ip_q     <= PidIpRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgHeardEnable: enable_q      <= cfg_wdata_i[0];
        CfgPidArp:      code_arp_q    <= cfg_wdata_i;
        CfgPidNetrom:   code_netrom_q <= cfg_wdata_i;
        CfgPidIp:       code_ip_q     <= cfg_wdata_i;
        default:        enable_q      <= enable_q;
      endcase
    end
  end

  // List head and occupancy; advance both when the link updates land.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= LinkNone;
      used_q <= '0;
    end else if (state_q == StLink2) begin
      head_q <= head_new_q;
      if (inc_q) begin
        used_q <= used_q + LW'(1);
      end
    end
  end

  // Item, walk and plan registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        call_q     <= station_call_i;
        ssid_q     <= station_ssid_i;
        now_q      <= now_seconds_i;
        pid_flag_q <= pid_flag;
        curr_q     <= head_q;
        prev_q     <= LinkNone;
        before_q   <= LinkNone;
        steps_q    <= '0;
        hit_q      <= 1'b0;
        evict_q    <= 1'b0;
        slot_q     <= '0;
        flags_q    <= FlagNone;
        tracked_q  <= enable_q;
      end
      StWalkCmp: begin
        if (match) begin
          hit_q       <= 1'b1;
          old_flags_q <= ent_rdata.flags;
          nxt_q       <= link_rdata;
        end else begin
          before_q <= prev_q;
          prev_q   <= curr_q;
          curr_q   <= link_rdata;
          steps_q  <= steps_q + LW'(1);
        end
      end
      StDecide: begin
        l1_en_q    <= 1'b0;
        l2_en_q    <= 1'b0;
        inc_q      <= 1'b0;
        l1_addr_q  <= prev_q[SW-1:0];
        l1_data_q  <= nxt_q;
        l2_data_q  <= head_q;
        head_new_q <= head_q;
        if (hit_q) begin
          // Unlink from its place and put it at the front.
          slot_q     <= curr_q[SW-1:0];
          flags_q    <= old_flags_q | pid_flag_q;
          l1_en_q    <= prev_q < LinkNone;
          l2_en_q    <= prev_q < LinkNone;
          l2_addr_q  <= curr_q[SW-1:0];
          head_new_q <= curr_q;
        end else if (used_q < LinkNone) begin
          // Take the next never-used slot.
          slot_q     <= used_q[SW-1:0];
          flags_q    <= pid_flag_q;
          l2_en_q    <= 1'b1;
          l2_addr_q  <= used_q[SW-1:0];
          head_new_q <= used_q;
          inc_q      <= 1'b1;
        end else if (prev_q >= LinkNone) begin
          // Full table with an empty list: reuse slot zero alone.
          slot_q     <= '0;
          flags_q    <= pid_flag_q;
          evict_q    <= 1'b1;
          l2_en_q    <= 1'b1;
          l2_addr_q  <= '0;
          l2_data_q  <= LinkNone;
          head_new_q <= '0;
        end else begin
          // Evict the tail and move it to the front.
          slot_q    <= prev_q[SW-1:0];
          flags_q   <= pid_flag_q;
          evict_q   <= 1'b1;
          l1_addr_q <= before_q[SW-1:0];
          l1_data_q <= LinkNone;
          l2_addr_q <= prev_q[SW-1:0];
          if (before_q < LinkNone) begin
            l1_en_q    <= 1'b1;
            l2_en_q    <= 1'b1;
            head_new_q <= prev_q;
          end
        end
      end
      default: begin
        curr_q <= curr_q;
      end
    endcase
  end

  // RAM write ports.
  assign ent_we          = state_q == StLink1;
  assign ent_wdata.call  = call_q;
  assign ent_wdata.ssid  = ssid_q;
  assign ent_wdata.flags = flags_q;
  assign ent_wdata.heard = now_q;

  assign link_we    = ((state_q == StLink1) && l1_en_q) || ((state_q == StLink2) && l2_en_q);
  assign link_waddr = (state_q == StLink1) ? l1_addr_q : l2_addr_q;
  assign link_wdata = (state_q == StLink1) ? l1_data_q : l2_data_q;

  hsmru_ram #(
    .Width (EntryW),
    .Depth (HeardSlots)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (slot_q),
    .wdata_i (ent_wdata),
    .raddr_i (curr_q[SW-1:0]),
    .rdata_o (ent_rdata)
  );

  hsmru_ram #(
    .Width (LW),
    .Depth (HeardSlots)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .raddr_i (curr_q[SW-1:0]),
    .rdata_o (link_rdata)
  );

  // Output register; load it from the result when free, hold it under stall.
  assign slot_ext = 32'(slot_q);
  assign used_ext = 32'(used_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == StDone) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == StDone) && out_free) begin
      out_slot_q    <= slot_ext[SlotOutW-1:0];
      out_hit_q     <= hit_q;
      out_evict_q   <= evict_q;
      out_flags_q   <= flags_q;
      out_count_q   <= used_ext[CountOutW-1:0];
      out_tracked_q <= tracked_q;
    end
  end

  assign in_stall_o       = state_q != StIdle;
  assign out_valid_o      = out_valid_q;
  assign slot_used_o      = out_slot_q;
  assign was_hit_o        = out_hit_q;
  assign evicted_oldest_o = out_evict_q;
  assign station_flags_o  = out_flags_q;
  assign entries_in_use_o = out_count_q;
  assign tracked_o        = out_tracked_q;

  // Occupancy never passes the table depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni) used_q <= LinkNone)
    else $error("occupancy above table depth");

  // The list is empty exactly when no slot is in use.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (used_q == '0) == (head_q == LinkNone))
    else $error("list head and occupancy disagree");

  // The walk never visits more entries than the table holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StWalkCmp) |-> (steps_q < LinkNone) && curr_valid)
    else $error("walk ran past table bounds");

  // An untracked result carries no slot, hit, eviction or flags.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_tracked_q) |->
      (out_slot_q == '0) && !out_hit_q && !out_evict_q && (out_flags_q == FlagNone))
    else $error("untracked result with table fields set");

  // Eviction only happens once the table is full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == StLink1) && evict_q) |-> (used_q == LinkNone))
    else $error("eviction with free slots left");

endmodule

FILE: rtl/hsmru_ram.sv
// Generic single-write, single-read RAM with registered read data.
module hsmru_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
